### rtl/ttg_pkg.sv
package ttg_pkg;

	localparam int unsigned PINK_ROWS_DEF = 7;
	localparam int unsigned PHASE_BITS_DEF = 32;
	localparam logic [63:0] RNG_SEED = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [17:0] SIN_A = 18'd102944;
	localparam logic [17:0] SIN_B = 18'd42048;
	localparam logic [17:0] SIN_C = 18'd4640;
	localparam int unsigned CFG_AW = 2;
	localparam int unsigned CFG_DW = 32;

	typedef enum logic [CFG_AW-1:0] {
		REG_MODE = 2'd0,
		REG_PHASE_STEP = 2'd1,
		REG_AMPLITUDE = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_SINE = 2'd0,
		MODE_WHITE = 2'd1,
		MODE_PINK = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		OP_NONE = 4'd0,
		OP_LOAD = 4'd1,
		OP_Z2 = 4'd2,
		OP_T1 = 4'd3,
		OP_T2 = 4'd4,
		OP_S = 4'd5,
		OP_SCALE = 4'd6,
		OP_ROUND = 4'd7,
		OP_RNG = 4'd8,
		OP_PINK = 4'd9,
		OP_PDIV = 4'd10,
		OP_CLEAR = 4'd11,
		OP_ZERO = 4'd12
	} op_t;

	typedef struct packed {
		logic restart;
		logic end_of_block;
	} in_t;

	typedef struct packed {
		logic signed [23:0] sample;
		logic block_last;
	} out_t;

	typedef struct packed {
		op_t op;
		logic div_start;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

endpackage

### rtl/ttg_ctrl.sv
module ttg_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input logic [1:0] mode,
	input logic silent,
	input ttg_pkg::sts_t sts,
	output ttg_pkg::cmd_t cmd,
	output logic capture
);

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_LOAD = 11'b000_0000_0010,
		ST_Z2 = 11'b000_0000_0100,
		ST_T1 = 11'b000_0000_1000,
		ST_T2 = 11'b000_0001_0000,
		ST_S = 11'b000_0010_0000,
		ST_SCALE = 11'b000_0100_0000,
		ST_RND = 11'b000_1000_0000,
		ST_PINK = 11'b001_0000_0000,
		ST_DIV = 11'b010_0000_0000,
		ST_OUT = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign capture = (state_q == ST_IDLE) && in_valid;

	always_comb begin
		state_d = state_q;
		cmd.op = ttg_pkg::OP_NONE;
		cmd.div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op = ttg_pkg::OP_LOAD;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (silent) begin
					cmd.op = ttg_pkg::OP_ZERO;
					state_d = ST_OUT;
				end else begin
					case (mode)
						ttg_pkg::MODE_SINE: begin
							cmd.op = ttg_pkg::OP_Z2;
							state_d = ST_Z2;
						end
						ttg_pkg::MODE_WHITE: begin
							cmd.op = ttg_pkg::OP_RNG;
							state_d = ST_SCALE;
						end
						default: begin
							cmd.op = ttg_pkg::OP_PINK;
							state_d = ST_PINK;
						end
					endcase
				end
			end
			ST_Z2: begin
				cmd.op = ttg_pkg::OP_T1;
				state_d = ST_T1;
			end
			ST_T1: begin
				cmd.op = ttg_pkg::OP_T2;
				state_d = ST_T2;
			end
			ST_T2: begin
				cmd.op = ttg_pkg::OP_S;
				state_d = ST_S;
			end
			ST_S: begin
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.op = ttg_pkg::OP_SCALE;
				state_d = ST_RND;
			end
			ST_RND: begin
				if (mode == ttg_pkg::MODE_PINK) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					cmd.op = ttg_pkg::OP_ROUND;
					state_d = ST_OUT;
				end
			end
			ST_PINK: begin
				state_d = ST_SCALE;
			end
			ST_DIV: begin
				if (sts.div_done) begin
					cmd.op = ttg_pkg::OP_PDIV;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/ttg_div.sv
module ttg_div #(
	parameter int unsigned NW = 27,
	parameter int unsigned DEN = 7
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [NW-1:0] num,
	output logic done,
	output logic [NW-1:0] quo
);

	// reciprocal multiply, exact for every num below 2**NW
	localparam int unsigned RL = $clog2(DEN);
	localparam int unsigned KS = NW + RL;
	localparam int unsigned PW = NW + KS + 1;
	localparam longint unsigned RECIP = ((64'd1 << KS) + 64'(DEN) - 64'd1) / 64'(DEN);

	logic done_q;
	logic [PW-1:0] prod_q;

	assign done = done_q;
	assign quo = NW'(prod_q >> KS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) prod_q <= PW'(num) * PW'(RECIP);
	end

endmodule

### rtl/ttg_dp.sv
module ttg_dp #(
	parameter int unsigned PINK_ROWS = ttg_pkg::PINK_ROWS_DEF,
	parameter int unsigned PHASE_BITS = ttg_pkg::PHASE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ttg_pkg::CFG_AW-1:0] cfg_addr,
	input logic [ttg_pkg::CFG_DW-1:0] cfg_data,
	input logic capture,
	input ttg_pkg::in_t in_data,
	input ttg_pkg::cmd_t cmd,
	output ttg_pkg::sts_t sts,
	output logic [1:0] mode,
	output logic silent,
	output ttg_pkg::out_t out_data
);

	localparam int unsigned RW = (PINK_ROWS > 1) ? $clog2(PINK_ROWS) : 1;
	localparam int unsigned SW = 16 + $clog2(PINK_ROWS + 1);
	localparam int unsigned DEN = PINK_ROWS * 1024;
	localparam int unsigned QW = 27;

	logic [1:0] mode_q;
	logic [31:0] step_q;
	logic [15:0] amp_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [63:0] rng_q;
	logic [15:0] rows_q [PINK_ROWS];
	logic [SW-1:0] sum_q;
	logic [31:0] cnt_q;
	logic restart_q, last_q;
	logic [16:0] z_q;
	logic [16:0] z2_q;
	logic [17:0] t_q;
	logic neg_q;
	logic [33:0] mag_q;
	logic signed [49:0] prod_q;
	logic signed [23:0] sample_q;

	logic [PHASE_BITS-1:0] phase_base;
	logic [31:0] p;
	logic [30:0] xm;
	logic [63:0] r1, r2, r3, rng_base;
	logic [31:0] cnt_nx;
	logic [4:0] tz;
	logic [RW-1:0] ridx;
	logic pink_hit;
	logic [SW+1:0] centered_abs;
	logic centered_neg;
	logic [QW-1:0] dquo;
	logic ddone;
	logic [QW-1:0] dnum;
	logic [49:0] abs_prod;
	logic [49:0] rnd;
	logic [49:0] qmag;
	logic signed [50:0] sres;

	assign mode = mode_q;
	assign silent = (amp_q == '0) || (mode_q == 2'd3) ||
		(mode_q == ttg_pkg::MODE_SINE && step_q[31]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			step_q <= '0;
			amp_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				ttg_pkg::REG_MODE: mode_q <= cfg_data[1:0];
				ttg_pkg::REG_PHASE_STEP: step_q <= cfg_data;
				ttg_pkg::REG_AMPLITUDE: amp_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign rng_base = restart_q ? ttg_pkg::RNG_SEED : rng_q;
	assign r1 = rng_base ^ (rng_base << 13);
	assign r2 = r1 ^ (r1 >> 7);
	assign r3 = r2 ^ (r2 << 17);

	// sine front end uses post-restart phase
	assign phase_base = restart_q ? '0 : phase_q;
	assign p = 32'(phase_base) << (32 - PHASE_BITS);
	assign xm = p[30] ? (31'h4000_0000 - {1'b0, p[29:0]}) : {1'b0, p[29:0]};

	assign cnt_nx = (restart_q ? 32'd0 : cnt_q) + 32'd1;
	always_comb begin
		tz = 5'd31;
		for (int i = 31; i >= 0; i--) begin
			if (cnt_nx[i]) tz = 5'(i);
		end
	end
	assign ridx = RW'(tz);
	assign pink_hit = (tz < 5'(PINK_ROWS));

	assign centered_neg = sum_q < SW'(PINK_ROWS * 32768);
	assign centered_abs = centered_neg ?
		(SW+2)'(PINK_ROWS * 65536) - {sum_q, 1'b0} :
		{sum_q, 1'b0} - (SW+2)'(PINK_ROWS * 65536);

	assign abs_prod = prod_q[49] ? 50'(-prod_q) : 50'(prod_q);
	assign dnum = QW'((abs_prod + 50'(DEN / 2)) >> 10);

	ttg_div #(.NW(QW), .DEN(PINK_ROWS)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.num(dnum),
		.done(ddone),
		.quo(dquo)
	);

	assign sts.div_done = ddone;

	always_comb begin
		if (mode_q == ttg_pkg::MODE_WHITE) rnd = abs_prod + 50'(1 << 25);
		else rnd = abs_prod + 50'd512;
		if (mode_q == ttg_pkg::MODE_WHITE) qmag = rnd >> 26;
		else qmag = rnd >> 10;
	end

	always_comb begin
		if (cmd.op == ttg_pkg::OP_PDIV) sres = 51'(dquo);
		else sres = 51'(qmag);
		if (prod_q[49]) sres = -sres;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			rng_q <= ttg_pkg::RNG_SEED;
			sum_q <= '0;
			cnt_q <= '0;
			for (int i = 0; i < PINK_ROWS; i++) rows_q[i] <= '0;
		end else if (cmd.op == ttg_pkg::OP_LOAD) begin
			// nothing; restart applied below with the mode op
		end else if (cmd.op == ttg_pkg::OP_ZERO) begin
			if (restart_q) begin
				phase_q <= '0;
				rng_q <= ttg_pkg::RNG_SEED;
				sum_q <= '0;
				cnt_q <= '0;
				for (int i = 0; i < PINK_ROWS; i++) rows_q[i] <= '0;
			end
		end else if (cmd.op == ttg_pkg::OP_Z2 || cmd.op == ttg_pkg::OP_RNG ||
			cmd.op == ttg_pkg::OP_PINK) begin
			if (cmd.op == ttg_pkg::OP_Z2)
				phase_q <= phase_base + step_q[31 -: PHASE_BITS];
			else
				phase_q <= phase_base;
			if (cmd.op == ttg_pkg::OP_RNG || (cmd.op == ttg_pkg::OP_PINK && pink_hit))
				rng_q <= r3;
			else
				rng_q <= rng_base;
			if (cmd.op == ttg_pkg::OP_PINK)
				cnt_q <= cnt_nx;
			else
				cnt_q <= restart_q ? '0 : cnt_q;
			if (cmd.op == ttg_pkg::OP_PINK && pink_hit)
				sum_q <= (restart_q ? '0 : sum_q) -
					SW'(restart_q ? 16'd0 : rows_q[ridx]) + SW'(r3[63:48]);
			else
				sum_q <= restart_q ? '0 : sum_q;
			for (int i = 0; i < PINK_ROWS; i++) begin
				if (cmd.op == ttg_pkg::OP_PINK && pink_hit && ridx == RW'(i))
					rows_q[i] <= r3[63:48];
				else if (restart_q)
					rows_q[i] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			restart_q <= in_data.restart;
			last_q <= in_data.end_of_block;
		end
		case (cmd.op)
			ttg_pkg::OP_Z2: begin
				z_q <= 17'(xm >> 14);
				neg_q <= p[31];
				z2_q <= 17'((34'(xm >> 14) * 34'(xm >> 14)) >> 16);
			end
			ttg_pkg::OP_T1: t_q <= ttg_pkg::SIN_B - 18'((35'(z2_q) * 35'(ttg_pkg::SIN_C)) >> 16);
			ttg_pkg::OP_T2: t_q <= ttg_pkg::SIN_A - 18'((35'(z2_q) * 35'(t_q)) >> 16);
			ttg_pkg::OP_S: mag_q <= 34'((35'(z_q) * 35'(t_q)) >> 16);
			ttg_pkg::OP_RNG: begin
				neg_q <= 1'b0;
				mag_q <= 34'({r3[63:32], 1'b0}) - 34'h0_FFFF_FFFF;
			end
			ttg_pkg::OP_SCALE: begin
				if (mode_q == ttg_pkg::MODE_PINK)
					prod_q <= centered_neg ?
						-$signed(50'(centered_abs) * 50'(amp_q)) :
						$signed(50'(centered_abs) * 50'(amp_q));
				else if (mode_q == ttg_pkg::MODE_WHITE)
					prod_q <= 50'($signed(mag_q)) * 50'($signed({1'b0, amp_q}));
				else
					prod_q <= neg_q ? -$signed(50'(mag_q) * 50'(amp_q)) :
						$signed(50'(mag_q) * 50'(amp_q));
			end
			ttg_pkg::OP_ROUND, ttg_pkg::OP_PDIV: begin
				if (sres > 51'sd8388607) sample_q <= 24'sd8388607;
				else if (sres < -51'sd8388608) sample_q <= -24'sd8388608;
				else sample_q <= sres[23:0];
			end
			ttg_pkg::OP_ZERO: sample_q <= '0;
			default: ;
		endcase
	end

	assign out_data.sample = sample_q;
	assign out_data.block_last = last_q;

endmodule

### rtl/test_tone_generator.sv
// state path after accept: silent LOAD, OUT; white LOAD, SCALE, RND, OUT;
// pink LOAD, PINK, SCALE, RND, DIV, OUT; sine LOAD, Z2, T1, T2, S, SCALE, RND, OUT
// one transaction at a time, next accepted the cycle after the result is taken
// the sine polynomial steps make sine the longest path
// reset (arst_n low) clears config registers and sum to zero, phase/rows/counter to zero, rng to seed
module test_tone_generator #(
	parameter int unsigned PINK_ROWS = ttg_pkg::PINK_ROWS_DEF,
	parameter int unsigned PHASE_BITS = ttg_pkg::PHASE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ttg_pkg::CFG_AW-1:0] cfg_addr,
	input logic [ttg_pkg::CFG_DW-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input ttg_pkg::in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output ttg_pkg::out_t out_data
);

	ttg_pkg::cmd_t cmd;
	ttg_pkg::sts_t sts;
	logic [1:0] mode;
	logic silent;
	logic capture;

	ttg_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mode(mode),
		.silent(silent),
		.sts(sts),
		.cmd(cmd),
		.capture(capture)
	);

	ttg_dp #(.PINK_ROWS(PINK_ROWS), .PHASE_BITS(PHASE_BITS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.capture(capture),
		.in_data(in_data),
		.cmd(cmd),
		.sts(sts),
		.mode(mode),
		.silent(silent),
		.out_data(out_data)
	);

endmodule
